// ----- hdl/shtp_rp_pkg.sv -----
// ----------------------------------------------------------------------------
// shtp_rp_pkg
// Shared types and constants for the sensor-hub report parser.
// ----------------------------------------------------------------------------
package shtp_rp_pkg;

  localparam int MAX_CARGO_DEF    = 1000;
  localparam int SENSOR_COUNT_DEF = 2;
  localparam int QUEUE_DEPTH      = 4;
  localparam int HDR_BYTES        = 4;

  localparam logic [7:0] SENSOR_CHANNEL = 8'd3;
  localparam logic [7:0] LEN_HI_MASK    = 8'h7F;

  // report sizes in bytes, ID byte included
  localparam logic [3:0] TIME_SIZE = 4'd5;
  localparam logic [3:0] VEC_SIZE  = 4'd10;
  localparam logic [3:0] QUAT_SIZE = 4'd14;

  // register indexes
  typedef enum logic [2:0] {
    REG_TIME     = 3'd0,
    REG_ACCEL    = 3'd1,
    REG_GYRO     = 3'd2,
    REG_MAGNET   = 3'd3,
    REG_LINACC   = 3'd4,
    REG_ROTATION = 3'd5
  } reg_idx_t;

  localparam logic [7:0] TIME_ID_RST     = 8'd251;
  localparam logic [7:0] ACCEL_ID_RST    = 8'd1;
  localparam logic [7:0] GYRO_ID_RST     = 8'd2;
  localparam logic [7:0] MAGNET_ID_RST   = 8'd3;
  localparam logic [7:0] LINACC_ID_RST   = 8'd4;
  localparam logic [7:0] ROTATION_ID_RST = 8'd5;

  // bit positions in the ID hit vector
  localparam int HIT_TIME     = 0;
  localparam int HIT_ACCEL    = 1;
  localparam int HIT_GYRO     = 2;
  localparam int HIT_MAGNET   = 3;
  localparam int HIT_LINACC   = 4;
  localparam int HIT_ROTATION = 5;
  localparam int HIT_COUNT    = 6;

  typedef enum logic [1:0] {
    EV_QUAT    = 2'd0,
    EV_REJECT  = 2'd1,
    EV_DISCARD = 2'd2
  } event_kind_t;

  // classified link word passed from front to back
  typedef struct packed {
    logic [7:0]           data;
    logic                 start;
    logic                 sensor;
    logic [HIT_COUNT-1:0] hit;
  } item_t;

endpackage

// ----- hdl/shtp_report_parser_core.sv -----
// ----------------------------------------------------------------------------
// shtp_report_parser_core
// Byte-serial sensor-hub packet parser: header check, report skipping and
// quaternion extraction.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in       sink       in_valid/in_ready    data_byte, packet_start, sensor_index
// out      source     out_valid/out_ready  event_kind, source_sensor, quat_*
// cfg      sink       cfg_write            cfg_index, cfg_data
//
// One byte per cycle while the queue has room; a word is written into the
// queue at the accepting edge, and the parser steps on it when it pops,
// which waits while a full result register is not drained.
// The core takes words while the 4-entry queue has room; the parser steps
// when a word is queued and the result register is empty or being drained.
// Synchronous reset clears the ID registers to defaults, queue and parser.
// ----------------------------------------------------------------------------
module shtp_report_parser_core #(
  parameter int MAX_CARGO    = shtp_rp_pkg::MAX_CARGO_DEF,
  parameter int SENSOR_COUNT = shtp_rp_pkg::SENSOR_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               packet_start,
  input  logic               sensor_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         event_kind,
  output logic               source_sensor,
  output logic signed [15:0] quat_real,
  output logic signed [15:0] quat_i,
  output logic signed [15:0] quat_j,
  output logic signed [15:0] quat_k,
  output logic               quat_all_zero
);

  shtp_rp_pkg::item_t front_word, back_word;
  logic               q_valid, q_ready;

  shtp_rp_front #(
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_byte    (data_byte),
    .packet_start (packet_start),
    .sensor_index (sensor_index),
    .word         (front_word)
  );

  shtp_rp_queue #(
    .DEPTH (shtp_rp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_word  (front_word),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_word   (back_word)
  );

  shtp_rp_back #(
    .MAX_CARGO (MAX_CARGO)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_word        (back_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_kind    (event_kind),
    .source_sensor (source_sensor),
    .quat_real     (quat_real),
    .quat_i        (quat_i),
    .quat_j        (quat_j),
    .quat_k        (quat_k),
    .quat_all_zero (quat_all_zero)
  );

endmodule

// ----- hdl/shtp_rp_front.sv -----
// ----------------------------------------------------------------------------
// shtp_rp_front
// Holds the report ID registers and classifies each incoming link byte.
// ----------------------------------------------------------------------------
module shtp_rp_front #(
  parameter int SENSOR_COUNT = shtp_rp_pkg::SENSOR_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic [7:0]          data_byte,
  input  logic                packet_start,
  input  logic                sensor_index,
  output shtp_rp_pkg::item_t  word
);

  logic [7:0] time_id, accel_id, gyro_id, magnet_id, linacc_id, rotation_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_id     <= shtp_rp_pkg::TIME_ID_RST;
      accel_id    <= shtp_rp_pkg::ACCEL_ID_RST;
      gyro_id     <= shtp_rp_pkg::GYRO_ID_RST;
      magnet_id   <= shtp_rp_pkg::MAGNET_ID_RST;
      linacc_id   <= shtp_rp_pkg::LINACC_ID_RST;
      rotation_id <= shtp_rp_pkg::ROTATION_ID_RST;
    end else if (cfg_write) begin
      case (shtp_rp_pkg::reg_idx_t'(cfg_index))
        shtp_rp_pkg::REG_TIME:     time_id     <= cfg_data;
        shtp_rp_pkg::REG_ACCEL:    accel_id    <= cfg_data;
        shtp_rp_pkg::REG_GYRO:     gyro_id     <= cfg_data;
        shtp_rp_pkg::REG_MAGNET:   magnet_id   <= cfg_data;
        shtp_rp_pkg::REG_LINACC:   linacc_id   <= cfg_data;
        shtp_rp_pkg::REG_ROTATION: rotation_id <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    word.data   = data_byte;
    word.start  = packet_start;
    word.sensor = (int'(sensor_index) >= SENSOR_COUNT) ? 1'(SENSOR_COUNT - 1)
                                                       : sensor_index;
    word.hit[shtp_rp_pkg::HIT_TIME]     = (data_byte == time_id);
    word.hit[shtp_rp_pkg::HIT_ACCEL]    = (data_byte == accel_id);
    word.hit[shtp_rp_pkg::HIT_GYRO]     = (data_byte == gyro_id);
    word.hit[shtp_rp_pkg::HIT_MAGNET]   = (data_byte == magnet_id);
    word.hit[shtp_rp_pkg::HIT_LINACC]   = (data_byte == linacc_id);
    word.hit[shtp_rp_pkg::HIT_ROTATION] = (data_byte == rotation_id);
  end

endmodule

// ----- hdl/shtp_rp_queue.sv -----
// ----------------------------------------------------------------------------
// shtp_rp_queue
// Small FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
module shtp_rp_queue #(
  parameter int DEPTH = shtp_rp_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  shtp_rp_pkg::item_t  push_word,
  output logic                pop_valid,
  input  logic                pop_ready,
  output shtp_rp_pkg::item_t  pop_word
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  shtp_rp_pkg::item_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic push, pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_word   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/shtp_rp_back.sv -----
// ----------------------------------------------------------------------------
// shtp_rp_back
// Packet parser state machine and registered result output.
// ----------------------------------------------------------------------------
module shtp_rp_back #(
  parameter int MAX_CARGO = shtp_rp_pkg::MAX_CARGO_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  shtp_rp_pkg::item_t  q_word,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          event_kind,
  output logic                source_sensor,
  output logic signed [15:0]  quat_real,
  output logic signed [15:0]  quat_i,
  output logic signed [15:0]  quat_j,
  output logic signed [15:0]  quat_k,
  output logic                quat_all_zero
);

  localparam int CW = $clog2(MAX_CARGO + 1);
  localparam logic [15:0] LEN_MIN = 16'(shtp_rp_pkg::HDR_BYTES);
  localparam logic [15:0] LEN_MAX = 16'(MAX_CARGO + shtp_rp_pkg::HDR_BYTES);

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_HDR     = 5'b00010,
    PH_ID      = 5'b00100,
    PH_BODY    = 5'b01000,
    PH_DISCARD = 5'b10000
  } phase_t;

  phase_t        phase, phase_next;
  logic [1:0]    hdr_cnt, hdr_cnt_next;
  logic [7:0]    len_lo, len_lo_next;
  logic [6:0]    len_hi, len_hi_next;
  logic          chan_ok, chan_ok_next;
  logic [CW-1:0] cargo_left, cargo_left_next;
  logic          sensor, sensor_next;
  logic [3:0]    rep_pos, rep_pos_next;
  logic [3:0]    rep_size, rep_size_next;
  logic          rep_quat, rep_quat_next;
  logic [7:0]    qbuf [8];

  logic          step, emit, qwr;
  logic [1:0]    kind;
  logic [CW-1:0] cargo_dec;
  logic [15:0]   len_full;
  logic          fit_time, fit_vec, fit_quat;
  logic [15:0]   qr, qi, qj, qk;

  assign q_ready   = !out_valid || out_ready;
  assign step      = q_valid && q_ready;
  assign cargo_dec = cargo_left - 1'b1;
  assign len_full  = {1'b0, len_hi, len_lo};

  // match-and-fit, checked against the cargo left after the ID byte
  assign fit_time = q_word.hit[shtp_rp_pkg::HIT_TIME]
                    && (cargo_dec >= CW'(shtp_rp_pkg::TIME_SIZE - 4'd1));
  assign fit_vec  = (q_word.hit[shtp_rp_pkg::HIT_ACCEL] || q_word.hit[shtp_rp_pkg::HIT_GYRO]
                    || q_word.hit[shtp_rp_pkg::HIT_MAGNET]
                    || q_word.hit[shtp_rp_pkg::HIT_LINACC])
                    && (cargo_dec >= CW'(shtp_rp_pkg::VEC_SIZE - 4'd1));
  assign fit_quat = q_word.hit[shtp_rp_pkg::HIT_ROTATION]
                    && (cargo_dec >= CW'(shtp_rp_pkg::QUAT_SIZE - 4'd1));

  assign qi = {qbuf[1], qbuf[0]};
  assign qj = {qbuf[3], qbuf[2]};
  assign qk = {qbuf[5], qbuf[4]};
  assign qr = {qbuf[7], qbuf[6]};

  always_comb begin
    phase_next      = phase;
    hdr_cnt_next    = hdr_cnt;
    len_lo_next     = len_lo;
    len_hi_next     = len_hi;
    chan_ok_next    = chan_ok;
    cargo_left_next = cargo_left;
    sensor_next     = sensor;
    rep_pos_next    = rep_pos;
    rep_size_next   = rep_size;
    rep_quat_next   = rep_quat;
    emit            = 1'b0;
    qwr             = 1'b0;
    kind            = shtp_rp_pkg::EV_QUAT;
    if (step) begin
      if (q_word.start) begin
        // a start mid-packet abandons the old packet
        sensor_next  = q_word.sensor;
        len_lo_next  = q_word.data;
        hdr_cnt_next = 2'd1;
        phase_next   = PH_HDR;
      end else begin
        unique case (phase)
          PH_IDLE: ;
          PH_HDR: begin
            if (hdr_cnt == 2'd1) begin
              len_hi_next  = 7'(q_word.data & shtp_rp_pkg::LEN_HI_MASK);
              hdr_cnt_next = 2'd2;
            end else if (hdr_cnt == 2'd2) begin
              chan_ok_next = (q_word.data == shtp_rp_pkg::SENSOR_CHANNEL);
              hdr_cnt_next = 2'd3;
            end else begin
              hdr_cnt_next = 2'd0;
              if (len_full <= LEN_MIN || len_full > LEN_MAX) begin
                phase_next = PH_IDLE;
                emit       = 1'b1;
                kind       = shtp_rp_pkg::EV_REJECT;
              end else begin
                cargo_left_next = CW'(len_full - LEN_MIN);
                phase_next      = PH_ID;
              end
            end
          end
          PH_ID: begin
            cargo_left_next = cargo_dec;
            rep_pos_next    = 4'd1;
            rep_quat_next   = 1'b0;
            if (chan_ok && fit_time) begin
              rep_size_next = shtp_rp_pkg::TIME_SIZE;
              phase_next    = PH_BODY;
            end else if (chan_ok && fit_vec) begin
              rep_size_next = shtp_rp_pkg::VEC_SIZE;
              phase_next    = PH_BODY;
            end else if (chan_ok && fit_quat) begin
              rep_size_next = shtp_rp_pkg::QUAT_SIZE;
              rep_quat_next = 1'b1;
              phase_next    = PH_BODY;
            end else begin
              phase_next = (cargo_dec != '0) ? PH_DISCARD : PH_IDLE;
              emit       = 1'b1;
              kind       = shtp_rp_pkg::EV_DISCARD;
            end
          end
          PH_BODY: begin
            cargo_left_next = cargo_dec;
            qwr             = rep_quat && (rep_pos >= 4'd4) && (rep_pos <= 4'd11);
            rep_pos_next    = rep_pos + 4'd1;
            if (rep_pos_next >= rep_size) begin
              phase_next = (cargo_dec != '0) ? PH_ID : PH_IDLE;
              emit       = rep_quat;
              kind       = shtp_rp_pkg::EV_QUAT;
            end
          end
          PH_DISCARD: begin
            cargo_left_next = cargo_dec;
            if (cargo_dec == '0) begin
              phase_next = PH_IDLE;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      hdr_cnt  <= 2'd0;
      rep_pos  <= 4'd0;
      rep_size <= 4'd0;
      rep_quat <= 1'b0;
      sensor   <= 1'b0;
    end else begin
      phase    <= phase_next;
      hdr_cnt  <= hdr_cnt_next;
      rep_pos  <= rep_pos_next;
      rep_size <= rep_size_next;
      rep_quat <= rep_quat_next;
      sensor   <= sensor_next;
    end
  end

  always_ff @(posedge clk) begin
    len_lo     <= len_lo_next;
    len_hi     <= len_hi_next;
    chan_ok    <= chan_ok_next;
    cargo_left <= cargo_left_next;
    if (qwr) begin
      qbuf[3'(rep_pos - 4'd4)] <= q_word.data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      event_kind    <= kind;
      source_sensor <= sensor;
      if (kind == shtp_rp_pkg::EV_QUAT) begin
        quat_real     <= qr;
        quat_i        <= qi;
        quat_j        <= qj;
        quat_k        <= qk;
        quat_all_zero <= ((qr | qi | qj | qk) == 16'd0);
      end else begin
        quat_real     <= '0;
        quat_i        <= '0;
        quat_j        <= '0;
        quat_k        <= '0;
        quat_all_zero <= 1'b0;
      end
    end
  end

endmodule
